>>> hdl/bpf_pkg.sv
package bpf_pkg;

  // sizes
  localparam int MAX_PATTERN = 8;
  localparam int MAX_BUFFER  = 65536;
  localparam int BYTE_W      = 8;
  localparam int LEN_W       = 4;
  localparam int POS_W       = 16;
  localparam int COUNT_W     = 17;
  localparam int CFG_ADDR_W  = 2;
  localparam int CFG_DATA_W  = 64;

  // register indexes on the configuration port
  localparam logic [CFG_ADDR_W-1:0] REG_PATTERN_BYTES = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_PATTERN_LEN   = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_BASE_OFFSET   = 2'd2;

  typedef logic [MAX_PATTERN-1:0][BYTE_W-1:0] pattern_t;
  typedef logic [MAX_PATTERN-1:0]             eq_row_t;
  typedef eq_row_t [MAX_PATTERN-1:0]          eq_matrix_t;

  // result of the compare array for one beat
  typedef struct packed {
    logic             full;
    logic [LEN_W-1:0] tail;
  } hit_t;

endpackage

>>> hdl/bpf_in_if.sv
interface bpf_in_if;
  logic                      valid;
  logic                      ready;
  logic [bpf_pkg::BYTE_W-1:0] data_byte;
  logic                      end_of_buffer;

  modport source (output valid, output data_byte, output end_of_buffer, input ready);
  modport sink   (input valid, input data_byte, input end_of_buffer, output ready);
endinterface

>>> hdl/bpf_out_if.sv
interface bpf_out_if;
  logic                      valid;
  logic                      ready;
  logic                      first_found;
  logic [bpf_pkg::POS_W-1:0] first_pos;
  logic                      last_found;
  logic [bpf_pkg::POS_W-1:0] last_pos;
  logic [bpf_pkg::LEN_W-1:0] tail_len;

  modport source (output valid, output first_found, output first_pos, output last_found,
                  output last_pos, output tail_len, input ready);
  modport sink   (input valid, input first_found, input first_pos, input last_found,
                  input last_pos, input tail_len, output ready);
endinterface

>>> hdl/bpf_cell.sv
module bpf_cell (
  input  logic                       clk,
  input  logic                       shift_en,
  input  logic [bpf_pkg::BYTE_W-1:0] byte_in,
  input  bpf_pkg::pattern_t          pattern,
  output logic [bpf_pkg::BYTE_W-1:0] byte_out,
  output bpf_pkg::eq_row_t           eq
);

  logic [bpf_pkg::BYTE_W-1:0] byte_r;
  logic [bpf_pkg::BYTE_W-1:0] byte_nxt;

  // take the neighbor's byte on every accepted beat
  assign byte_nxt = shift_en ? byte_in : byte_r;

  always_ff @(posedge clk) begin
    byte_r <= byte_nxt;
  end

  assign byte_out = byte_r;

  // compare the byte this cell holds after the beat with every pattern byte
  always_comb begin
    for (int j = 0; j < bpf_pkg::MAX_PATTERN; j++) begin
      eq[j] = (byte_in == pattern[j]);
    end
  end

endmodule

>>> hdl/bpf_match.sv
module bpf_match (
  input  bpf_pkg::eq_matrix_t        eq,
  input  logic [bpf_pkg::LEN_W-1:0]  len,
  input  logic                       len_ok,
  output bpf_pkg::hit_t              hit
);

  logic [bpf_pkg::MAX_PATTERN:1] pfx;

  // suffix of length t equals pattern prefix of length t
  always_comb begin
    for (int t = 1; t <= bpf_pkg::MAX_PATTERN; t++) begin
      pfx[t] = 1'b1;
      for (int a = 0; a < bpf_pkg::MAX_PATTERN; a++) begin
        if (a < t) begin
          pfx[t] = pfx[t] & eq[a][t-1-a];
        end
      end
    end
  end

  // full match and longest tail, both gated by enough bytes seen
  always_comb begin
    hit.full = 1'b0;
    hit.tail = '0;
    for (int t = 1; t <= bpf_pkg::MAX_PATTERN; t++) begin
      if (len_ok && (bpf_pkg::LEN_W'(t) <= len) && pfx[t]) begin
        hit.tail = bpf_pkg::LEN_W'(t);
      end
      if (len_ok && (bpf_pkg::LEN_W'(t) == len) && pfx[t]) begin
        hit.full = 1'b1;
      end
    end
  end

endmodule

>>> hdl/byte_pattern_finder_top.sv
// Byte pattern finder: scans a buffer one byte per beat for a pattern of up to
// eight bytes and, on the last byte of the buffer (end_of_buffer, or the 65536th
// byte), returns one result beat with the first and last match start plus
// base_offset and the longest buffer tail that is a pattern prefix. Bytes are
// taken one per clock while not stalled; a row of eight byte cells shifts on
// every accepted beat and compares against all pattern bytes in the same cycle.
// The result sits in an output register and is valid the cycle after the last
// byte is taken. The input stalls for as long as a result waits in that
// register and the output side is not ready.
// Write the registers only while no buffer is in flight.
module byte_pattern_finder_top (
  input  logic                           clk,
  input  logic                           rst_n,
  bpf_in_if.sink                         in_bus,
  bpf_out_if.source                      out_bus,
  input  logic                           cfg_we,
  input  logic [bpf_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [bpf_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int NP = bpf_pkg::MAX_PATTERN;

  // configuration registers
  bpf_pkg::pattern_t          pat_r;
  logic [bpf_pkg::LEN_W-1:0]  plen_r;
  logic [bpf_pkg::POS_W-1:0]  base_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pat_r  <= '0;
      plen_r <= bpf_pkg::LEN_W'(1);
      base_r <= '0;
    end else if (cfg_we) begin
      case (cfg_addr)
        bpf_pkg::REG_PATTERN_BYTES: pat_r  <= cfg_data;
        bpf_pkg::REG_PATTERN_LEN:   plen_r <= cfg_data[bpf_pkg::LEN_W-1:0];
        bpf_pkg::REG_BASE_OFFSET:   base_r <= cfg_data[bpf_pkg::POS_W-1:0];
        default: ;
      endcase
    end
  end

  // handshake
  logic out_valid_r;
  logic accept;

  assign in_bus.ready = !out_valid_r || out_bus.ready;
  assign accept       = in_bus.valid && in_bus.ready;

  // row of byte cells, newest byte in cell 0
  logic [NP-1:0][bpf_pkg::BYTE_W-1:0] cell_byte;
  bpf_pkg::eq_matrix_t                eq;

  for (genvar k = 0; k < NP; k++) begin : g_cell
    logic [bpf_pkg::BYTE_W-1:0] feed;
    if (k == 0) begin : g_head
      assign feed = in_bus.data_byte;
    end else begin : g_body
      assign feed = cell_byte[k-1];
    end
    bpf_cell u_cell (
      .clk      (clk),
      .shift_en (accept),
      .byte_in  (feed),
      .pattern  (pat_r),
      .byte_out (cell_byte[k]),
      .eq       (eq[k])
    );
  end

  // buffer state
  logic [bpf_pkg::COUNT_W-1:0] cnt_r, cnt_nxt;
  logic                        seen_r, seen_nxt;
  logic [bpf_pkg::POS_W-1:0]   early_r, early_nxt;
  logic [bpf_pkg::POS_W-1:0]   late_r, late_nxt;

  logic [bpf_pkg::LEN_W-1:0]   len_eff;
  logic [bpf_pkg::COUNT_W-1:0] cnt_new;
  logic                        len_ok;
  logic                        last_beat;
  logic [bpf_pkg::POS_W-1:0]   start;
  bpf_pkg::hit_t               hit;

  // pattern length clamped to the cell count
  assign len_eff = (plen_r > bpf_pkg::LEN_W'(NP)) ? bpf_pkg::LEN_W'(NP) : plen_r;
  assign cnt_new = cnt_r + bpf_pkg::COUNT_W'(1);
  assign len_ok  = (len_eff != '0) && (cnt_new >= bpf_pkg::COUNT_W'(len_eff));
  assign start   = cnt_new[bpf_pkg::POS_W-1:0] - bpf_pkg::POS_W'(len_eff);
  assign last_beat = in_bus.end_of_buffer ||
                     (cnt_new == bpf_pkg::COUNT_W'(bpf_pkg::MAX_BUFFER));

  bpf_match u_match (
    .eq     (eq),
    .len    (len_eff),
    .len_ok (len_ok),
    .hit    (hit)
  );

  // match bookkeeping including this beat
  logic                      seen_now;
  logic [bpf_pkg::POS_W-1:0] early_now;
  logic [bpf_pkg::POS_W-1:0] late_now;

  assign seen_now  = seen_r || hit.full;
  assign early_now = seen_r ? early_r : start;
  assign late_now  = hit.full ? start : late_r;

  always_comb begin
    cnt_nxt   = cnt_r;
    seen_nxt  = seen_r;
    early_nxt = early_r;
    late_nxt  = late_r;
    if (accept) begin
      if (last_beat) begin
        cnt_nxt   = '0;
        seen_nxt  = 1'b0;
        early_nxt = '0;
        late_nxt  = '0;
      end else begin
        cnt_nxt   = cnt_new;
        seen_nxt  = seen_now;
        early_nxt = early_now;
        late_nxt  = late_now;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r   <= '0;
      seen_r  <= 1'b0;
      early_r <= '0;
      late_r  <= '0;
    end else begin
      cnt_r   <= cnt_nxt;
      seen_r  <= seen_nxt;
      early_r <= early_nxt;
      late_r  <= late_nxt;
    end
  end

  // output register
  logic                      out_valid_nxt;
  logic                      found_r;
  logic [bpf_pkg::POS_W-1:0] first_pos_r;
  logic [bpf_pkg::POS_W-1:0] last_pos_r;
  logic [bpf_pkg::LEN_W-1:0] tail_r;
  logic                      load;

  assign load = accept && last_beat;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (out_bus.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      found_r     <= seen_now;
      first_pos_r <= seen_now ? (early_now + base_r) : '0;
      last_pos_r  <= seen_now ? (late_now + base_r) : '0;
      tail_r      <= hit.tail;
    end
  end

  assign out_bus.valid       = out_valid_r;
  assign out_bus.first_found = found_r;
  assign out_bus.first_pos   = first_pos_r;
  assign out_bus.last_found  = found_r;
  assign out_bus.last_pos    = last_pos_r;
  assign out_bus.tail_len    = tail_r;

endmodule
